[src/sgr_pkg.sv]
// ----------------------------------------------------------------------------
// sgr_pkg: shared types and constants of the supercover grid raycast core
// Holds the map geometry, the item and register layout, the controller
// states and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int GRID_SIDE = 64;
  localparam int LAYERS    = 4;
  localparam int COORD_W   = 6;
  localparam int LAYER_W   = 2;
  localparam int ROWS      = LAYERS * GRID_SIDE;
  localparam int ROW_W     = $clog2(ROWS);

  // Last column or row of the stored grid.
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIDE - 1);

  // Holds (2n+1)*d for n, d up to the grid side.
  localparam int PROD_W = 14;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int LCNT_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 2'd2;

  localparam logic MODE_WRITE = 1'b0;

  typedef struct packed {
    logic               mode;
    logic [LAYER_W-1:0] layer;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               tile_value;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_WR_MOD,
    ST_TEST,
    ST_SIDE_H,
    ST_SIDE_V,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ASEL_CUR,
    ASEL_NEXT,
    ASEL_SIDE_H,
    ASEL_SIDE_V
  } addr_sel_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_INVALID,
    RES_PLAIN,
    RES_HIT_CUR,
    RES_HIT_H,
    RES_HIT_V
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      clr;
    logic      wr_tile;
    logic      step;
    logic      out_load;
    addr_sel_t addr_sel;
    res_kind_t res_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic item_write;
    logic item_ok;
    logic cur_hit;
    logic at_end;
    logic corner;
    logic out_free;
  } dp_stat_t;

endpackage

[src/supercover_grid_raycast_core.sv]
// ----------------------------------------------------------------------------
// supercover_grid_raycast_core: supercover line raycast over a tile bitmap
// Stores one blocked bit per tile and layer and walks rays through it.
// ----------------------------------------------------------------------------
// After reset the core clears the bitmap, one 64-bit row per cycle, and takes
// no word until that is done. A tile write keeps the core busy from acceptance
// until it can accept again, through the accept cycle, one row read, one row
// write and the output load. A raycast keeps it busy through acceptance, one
// cell read per cell visited, two more reads per exact corner crossing, where
// the two side cells are read one after the other, and the output load. The
// single read port of the bitmap, one cell per cycle, paces the walk. The
// result enters the output register from the done state, which stalls while
// the previous result still waits there. One item is in work at a time, but a
// new word is accepted while the last result still waits in the output
// register.
module supercover_grid_raycast_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: layer, start_x, start_y, end_x, end_y, tile_value.
  input  logic [sgr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: mode.
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: status, blocked, hit_x, hit_y.
  output logic [sgr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sgr_pkg::item_t     in_item;
  sgr_pkg::ctrl_cmd_t cmd;
  sgr_pkg::dp_stat_t  stat;
  sgr_pkg::state_t    state;
  logic                        out_status;
  logic                        out_hit_flag;
  logic [sgr_pkg::COORD_W-1:0] out_hit_x;
  logic [sgr_pkg::COORD_W-1:0] out_hit_y;

  always_comb begin
    in_item.mode       = s_axis_tuser;
    in_item.layer      = s_axis_tdata[1:0];
    in_item.start_x    = s_axis_tdata[7:2];
    in_item.start_y    = s_axis_tdata[13:8];
    in_item.end_x      = s_axis_tdata[19:14];
    in_item.end_y      = s_axis_tdata[25:20];
    in_item.tile_value = s_axis_tdata[26];
  end

  assign m_axis_tdata = {2'b00, out_hit_y, out_hit_x, out_hit_flag, out_status};

  sgr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd),
    .state   (state)
  );

  sgr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_status  (out_status),
    .out_hit_flag(out_hit_flag),
    .out_hit_x   (out_hit_x),
    .out_hit_y   (out_hit_y)
  );

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == sgr_pkg::ST_CLEAR) |-> !s_axis_tready)
    else $error("input ready during bitmap clear");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted while an item is in work");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == sgr_pkg::ST_DONE))
    else $error("result appeared outside the done state");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1]) |-> !m_axis_tdata[0])
    else $error("blocked result with invalid status");
`endif

endmodule

[src/sgr_ram.sv]
// ----------------------------------------------------------------------------
// sgr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/sgr_ctrl.sv]
// ----------------------------------------------------------------------------
// sgr_ctrl: controller of the supercover grid raycast core
// Sequences the bitmap clear, tile writes and the cell-by-cell ray walk.
// ----------------------------------------------------------------------------
module sgr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgr_pkg::dp_stat_t   stat,
  output sgr_pkg::ctrl_cmd_t  cmd,
  output sgr_pkg::state_t     state
);

  sgr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sgr_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_next = sgr_pkg::ST_IDLE;
      end
      sgr_pkg::ST_IDLE: begin
        if (in_valid) state_next = sgr_pkg::ST_LOAD;
      end
      sgr_pkg::ST_LOAD: begin
        if (!stat.item_ok) begin
          state_next = sgr_pkg::ST_DONE;
        end else if (stat.item_write) begin
          state_next = sgr_pkg::ST_WR_MOD;
        end else begin
          state_next = sgr_pkg::ST_TEST;
        end
      end
      sgr_pkg::ST_WR_MOD: state_next = sgr_pkg::ST_DONE;
      sgr_pkg::ST_TEST: begin
        if (stat.cur_hit || stat.at_end) begin
          state_next = sgr_pkg::ST_DONE;
        end else if (stat.corner) begin
          state_next = sgr_pkg::ST_SIDE_H;
        end
      end
      sgr_pkg::ST_SIDE_H: begin
        state_next = stat.cur_hit ? sgr_pkg::ST_DONE : sgr_pkg::ST_SIDE_V;
      end
      sgr_pkg::ST_SIDE_V: begin
        state_next = stat.cur_hit ? sgr_pkg::ST_DONE : sgr_pkg::ST_TEST;
      end
      sgr_pkg::ST_DONE: begin
        if (stat.out_free) state_next = sgr_pkg::ST_IDLE;
      end
      default: state_next = sgr_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.addr_sel = sgr_pkg::ASEL_CUR;
    cmd.res_kind = sgr_pkg::RES_NONE;
    case (state)
      sgr_pkg::ST_CLEAR: cmd.clr = 1'b1;
      sgr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sgr_pkg::ST_LOAD: begin
        if (!stat.item_ok) cmd.res_kind = sgr_pkg::RES_INVALID;
      end
      sgr_pkg::ST_WR_MOD: begin
        cmd.wr_tile  = 1'b1;
        cmd.res_kind = sgr_pkg::RES_PLAIN;
      end
      sgr_pkg::ST_TEST: begin
        if (stat.cur_hit) begin
          cmd.res_kind = sgr_pkg::RES_HIT_CUR;
        end else if (stat.at_end) begin
          cmd.res_kind = sgr_pkg::RES_PLAIN;
        end else if (stat.corner) begin
          cmd.addr_sel = sgr_pkg::ASEL_SIDE_H;
        end else begin
          cmd.step     = 1'b1;
          cmd.addr_sel = sgr_pkg::ASEL_NEXT;
        end
      end
      sgr_pkg::ST_SIDE_H: begin
        if (stat.cur_hit) begin
          cmd.res_kind = sgr_pkg::RES_HIT_H;
        end else begin
          cmd.addr_sel = sgr_pkg::ASEL_SIDE_V;
        end
      end
      sgr_pkg::ST_SIDE_V: begin
        if (stat.cur_hit) begin
          cmd.res_kind = sgr_pkg::RES_HIT_V;
        end else begin
          // Both side cells are free, so take the diagonal step.
          cmd.step     = 1'b1;
          cmd.addr_sel = sgr_pkg::ASEL_NEXT;
        end
      end
      sgr_pkg::ST_DONE: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[src/sgr_datapath.sv]
// ----------------------------------------------------------------------------
// sgr_datapath: datapath of the supercover grid raycast core
// Holds the configuration, the item, the walk position and error terms,
// the row-wide tile bitmap and the result and output registers.
// ----------------------------------------------------------------------------
module sgr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  sgr_pkg::item_t                      in_item,
  input  sgr_pkg::ctrl_cmd_t                  cmd,
  output sgr_pkg::dp_stat_t                   stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_status,
  output logic                                out_hit_flag,
  output logic [sgr_pkg::COORD_W-1:0]         out_hit_x,
  output logic [sgr_pkg::COORD_W-1:0]         out_hit_y
);

  logic [sgr_pkg::CFG_DATA_W-1:0] map_width;
  logic [sgr_pkg::CFG_DATA_W-1:0] map_height;
  logic [sgr_pkg::LCNT_W-1:0]     layer_count;

  sgr_pkg::item_t               item;
  logic [sgr_pkg::COORD_W-1:0]  x;
  logic [sgr_pkg::COORD_W-1:0]  y;
  logic [sgr_pkg::COORD_W-1:0]  dx;
  logic [sgr_pkg::COORD_W-1:0]  dy;
  logic                         x_neg;
  logic                         y_neg;
  logic [sgr_pkg::PROD_W-1:0]   lhs;
  logic [sgr_pkg::PROD_W-1:0]   rhs;
  logic [sgr_pkg::ROW_W-1:0]    clr_cnt;

  logic [sgr_pkg::COORD_W-1:0]  rd_col;
  logic                         rd_ok;
  logic                         res_status;
  logic                         res_blocked;
  logic [sgr_pkg::COORD_W-1:0]  res_x;
  logic [sgr_pkg::COORD_W-1:0]  res_y;

  logic [sgr_pkg::COORD_W-1:0]  xs;
  logic [sgr_pkg::COORD_W-1:0]  ys;
  logic                         xs_ok;
  logic                         ys_ok;
  logic                         corner;
  logic                         x_step;
  logic [sgr_pkg::COORD_W-1:0]  nxt_x;
  logic [sgr_pkg::COORD_W-1:0]  nxt_y;
  logic [sgr_pkg::COORD_W-1:0]  in_dx;
  logic [sgr_pkg::COORD_W-1:0]  in_dy;
  logic [sgr_pkg::PROD_W-1:0]   dx2;
  logic [sgr_pkg::PROD_W-1:0]   dy2;
  logic                         start_ok;
  logic                         end_ok;
  logic [sgr_pkg::COORD_W-1:0]  pass_x;
  logic [sgr_pkg::COORD_W-1:0]  pass_y;

  logic                         ram_we;
  logic [sgr_pkg::ROW_W-1:0]    ram_waddr;
  logic [sgr_pkg::GRID_SIDE-1:0] ram_wdata;
  logic [sgr_pkg::ROW_W-1:0]    ram_raddr;
  logic [sgr_pkg::GRID_SIDE-1:0] ram_rdata;
  logic [sgr_pkg::GRID_SIDE-1:0] row_mod;
  logic [sgr_pkg::COORD_W-1:0]  rd_col_next;
  logic                         rd_ok_next;

  // Neighbors along the step direction and whether they lie in storage.
  assign xs     = x_neg ? x - 1'b1 : x + 1'b1;
  assign ys     = y_neg ? y - 1'b1 : y + 1'b1;
  assign xs_ok  = x_neg ? (x != '0) : (x != sgr_pkg::COORD_MAX);
  assign ys_ok  = y_neg ? (y != '0) : (y != sgr_pkg::COORD_MAX);
  assign corner = (lhs == rhs);
  assign x_step = (lhs < rhs);
  assign nxt_x  = (corner || x_step) ? xs : x;
  assign nxt_y  = (corner || !x_step) ? ys : y;
  assign dx2    = {(sgr_pkg::PROD_W - sgr_pkg::COORD_W - 1)'(0), dx, 1'b0};
  assign dy2    = {(sgr_pkg::PROD_W - sgr_pkg::COORD_W - 1)'(0), dy, 1'b0};

  assign in_dx = (in_item.end_x >= in_item.start_x) ? in_item.end_x - in_item.start_x
                                                    : in_item.start_x - in_item.end_x;
  assign in_dy = (in_item.end_y >= in_item.start_y) ? in_item.end_y - in_item.start_y
                                                    : in_item.start_y - in_item.end_y;

  assign start_ok = ({1'b0, item.layer} < layer_count) &&
                    ({1'b0, item.start_x} < map_width) &&
                    ({1'b0, item.start_y} < map_height);
  assign end_ok   = ({1'b0, item.end_x} < map_width) &&
                    ({1'b0, item.end_y} < map_height);

  // A write reports its own tile, a ray its end cell.
  assign pass_x = (item.mode == sgr_pkg::MODE_WRITE) ? item.start_x : item.end_x;
  assign pass_y = (item.mode == sgr_pkg::MODE_WRITE) ? item.start_y : item.end_y;

  always_comb begin
    stat.clr_last   = (clr_cnt == sgr_pkg::ROW_W'(sgr_pkg::ROWS - 1));
    stat.item_write = (item.mode == sgr_pkg::MODE_WRITE);
    stat.item_ok    = start_ok && ((item.mode == sgr_pkg::MODE_WRITE) || end_ok);
    stat.cur_hit    = rd_ok && ram_rdata[rd_col];
    stat.at_end     = (x == item.end_x) && (y == item.end_y);
    stat.corner     = corner;
    stat.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    row_mod    = ram_rdata;
    row_mod[x] = item.tile_value;
  end

  assign ram_we    = cmd.clr || cmd.wr_tile;
  assign ram_waddr = cmd.clr ? clr_cnt : {item.layer, y};
  assign ram_wdata = cmd.clr ? '0 : row_mod;

  always_comb begin
    ram_raddr   = {item.layer, y};
    rd_col_next = x;
    rd_ok_next  = 1'b1;
    case (cmd.addr_sel)
      sgr_pkg::ASEL_CUR: begin
        ram_raddr   = {item.layer, y};
        rd_col_next = x;
      end
      sgr_pkg::ASEL_NEXT: begin
        ram_raddr   = {item.layer, nxt_y};
        rd_col_next = nxt_x;
      end
      sgr_pkg::ASEL_SIDE_H: begin
        ram_raddr   = {item.layer, y};
        rd_col_next = xs;
        rd_ok_next  = xs_ok;
      end
      sgr_pkg::ASEL_SIDE_V: begin
        ram_raddr   = {item.layer, ys};
        rd_col_next = x;
        rd_ok_next  = ys_ok;
      end
      default: begin
        ram_raddr   = {item.layer, y};
        rd_col_next = x;
      end
    endcase
  end

  sgr_ram #(
    .WIDTH(sgr_pkg::GRID_SIDE),
    .DEPTH(sgr_pkg::ROWS)
  ) u_tile_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= sgr_pkg::CFG_DATA_W'(sgr_pkg::GRID_SIDE);
      map_height  <= sgr_pkg::CFG_DATA_W'(sgr_pkg::GRID_SIDE);
      layer_count <= sgr_pkg::LCNT_W'(sgr_pkg::LAYERS);
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sgr_pkg::CFG_MAP_WIDTH:   map_width   <= cfg_data;
          sgr_pkg::CFG_MAP_HEIGHT:  map_height  <= cfg_data;
          sgr_pkg::CFG_LAYER_COUNT: layer_count <= cfg_data[sgr_pkg::LCNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_col <= rd_col_next;
    rd_ok  <= rd_ok_next;
    if (cmd.load) begin
      item  <= in_item;
      x     <= in_item.start_x;
      y     <= in_item.start_y;
      dx    <= in_dx;
      dy    <= in_dy;
      x_neg <= !(in_item.start_x < in_item.end_x);
      y_neg <= !(in_item.start_y < in_item.end_y);
      lhs   <= sgr_pkg::PROD_W'(in_dy);
      rhs   <= sgr_pkg::PROD_W'(in_dx);
    end else if (cmd.step) begin
      x <= nxt_x;
      y <= nxt_y;
      if (corner || x_step) lhs <= lhs + dy2;
      if (corner || !x_step) rhs <= rhs + dx2;
    end
    case (cmd.res_kind)
      sgr_pkg::RES_INVALID: begin
        res_status  <= 1'b1;
        res_blocked <= 1'b0;
        res_x       <= pass_x;
        res_y       <= pass_y;
      end
      sgr_pkg::RES_PLAIN: begin
        res_status  <= 1'b0;
        res_blocked <= 1'b0;
        res_x       <= pass_x;
        res_y       <= pass_y;
      end
      sgr_pkg::RES_HIT_CUR: begin
        res_status  <= 1'b0;
        res_blocked <= 1'b1;
        res_x       <= x;
        res_y       <= y;
      end
      sgr_pkg::RES_HIT_H: begin
        res_status  <= 1'b0;
        res_blocked <= 1'b1;
        res_x       <= xs;
        res_y       <= y;
      end
      sgr_pkg::RES_HIT_V: begin
        res_status  <= 1'b0;
        res_blocked <= 1'b1;
        res_x       <= x;
        res_y       <= ys;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_status   <= res_status;
      out_hit_flag <= res_blocked;
      out_hit_x    <= res_x;
      out_hit_y    <= res_y;
    end
  end

endmodule
